/* hdl/fht_pkg.sv */
// ----------------------------------------------------------------------------
// fht_pkg
// Types, constants and codes shared by the flow handshake tracker modules.
// ----------------------------------------------------------------------------
package fht_pkg;

    localparam int FLOW_ENTRIES_DEF = 64;

    localparam int IP_W     = 32;
    localparam int PORT_W   = 16;
    localparam int TOS_W    = 8;
    localparam int DSCP_W   = 6;
    localparam int ECN_W    = 2;
    localparam int KEY_W    = 2 * IP_W + 2 * PORT_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [DSCP_W-1:0] DATA_CLASS_RST   = 6'd1;
    localparam logic [DSCP_W-1:0] CREDIT_CLASS_RST = 6'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_CLASS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CREDIT_CLASS = 2'd1;

    // path codes
    localparam logic CMD_TX = 1'b0;
    localparam logic CMD_RX = 1'b1;

    typedef enum logic [2:0] {
        ST_CLOSED      = 3'd0,
        ST_SYN_SENT    = 3'd1,
        ST_SYN_RCVD    = 3'd2,
        ST_SYNACK_SENT = 3'd3,
        ST_SYNACK_RCVD = 3'd4,
        ST_ESTABLISHED = 3'd5
    } t_conn_state;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_CHECK,
        FSM_READ,
        FSM_CMP,
        FSM_MISS,
        FSM_FINISH
    } t_fsm;

    typedef struct packed {
        logic load;      // latch the input word
        logic rd_en;     // read table at current index
        logic inc_idx;   // step to the next entry
        logic hit;       // take the entry just compared
        logic miss;      // allocate or flag full
        logic finish;    // apply handshake step and emit result
    } t_dp_cmd;

    typedef struct packed {
        logic tcp;       // latched word is IPv4/TCP
        logic empty;     // no flows stored yet
        logic hit;       // read key matches
        logic last;      // current index is the last stored flow
    } t_dp_sts;

endpackage

/* hdl/fht_ctrl.sv */
// ----------------------------------------------------------------------------
// fht_ctrl
// Sequencer for the tracker: for TCP words a linear scan of stored flows, then
// allocate or update; other words skip both. Then emit one result.
// ----------------------------------------------------------------------------
module fht_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  fht_pkg::t_dp_sts i_sts,
    output fht_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);
    import fht_pkg::*;

    t_fsm r_state;
    t_fsm n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FSM_IDLE: begin
                if (i_start) begin
                    n_state = FSM_CHECK;
                end
            end
            FSM_CHECK: begin
                priority if (!i_sts.tcp) begin
                    n_state = FSM_FINISH;
                end else if (i_sts.empty) begin
                    n_state = FSM_MISS;
                end else begin
                    n_state = FSM_READ;
                end
            end
            FSM_READ: begin
                n_state = FSM_CMP;
            end
            FSM_CMP: begin
                priority if (i_sts.hit) begin
                    n_state = FSM_FINISH;
                end else if (i_sts.last) begin
                    n_state = FSM_MISS;
                end else begin
                    n_state = FSM_READ;
                end
            end
            FSM_MISS: begin
                n_state = FSM_FINISH;
            end
            FSM_FINISH: begin
                n_state = FSM_IDLE;
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            FSM_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            FSM_CHECK: begin
            end
            FSM_READ: begin
                o_cmd.rd_en = 1'b1;
            end
            FSM_CMP: begin
                o_cmd.hit     = i_sts.hit;
                o_cmd.inc_idx = !i_sts.hit && !i_sts.last;
            end
            FSM_MISS: begin
                o_cmd.miss = 1'b1;
            end
            FSM_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/fht_dp.sv */
// ----------------------------------------------------------------------------
// fht_dp
// Datapath: flow key and state tables, fill count, class registers,
// handshake step and result registers.
// ----------------------------------------------------------------------------
module fht_dp #(
    parameter int FLOW_ENTRIES = fht_pkg::FLOW_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fht_pkg::t_dp_cmd              i_cmd,
    output fht_pkg::t_dp_sts              o_sts,
    input  logic                          i_cfg_we,
    input  logic [fht_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fht_pkg::DSCP_W-1:0]    i_cfg_data,
    input  logic                          i_cmd_dir,
    input  logic                          i_is_ipv4_tcp,
    input  logic [fht_pkg::IP_W-1:0]      i_src_ip,
    input  logic [fht_pkg::IP_W-1:0]      i_dst_ip,
    input  logic [fht_pkg::PORT_W-1:0]    i_src_port,
    input  logic [fht_pkg::PORT_W-1:0]    i_dst_port,
    input  logic [fht_pkg::TOS_W-1:0]     i_tos,
    input  logic                          i_syn,
    input  logic                          i_ack,
    output logic                          o_valid,
    output logic                          o_forward,
    output logic [fht_pkg::TOS_W-1:0]     o_new_tos,
    output logic [2:0]                    o_conn_state,
    output logic                          o_table_full,
    output logic                          o_established
);
    import fht_pkg::*;

    localparam int IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CW = $clog2(FLOW_ENTRIES + 1);

    // tables
    logic [KEY_W-1:0] r_key_mem [FLOW_ENTRIES];
    t_conn_state      r_st_mem  [FLOW_ENTRIES];
    logic [KEY_W-1:0] r_key_rd;
    t_conn_state      r_st_rd;

    // control state
    logic [CW-1:0]     r_next_free;
    logic [DSCP_W-1:0] r_data_class;
    logic [DSCP_W-1:0] r_credit_class;
    logic              r_valid;

    // latched word
    logic [KEY_W-1:0] r_key;
    logic             r_dir;
    logic             r_tcp;
    logic [TOS_W-1:0] r_tos;
    logic             r_syn;
    logic             r_ack;
    logic [IW-1:0]    r_idx;
    logic             r_have;
    t_conn_state      r_old;

    // result word
    logic             r_forward;
    logic [TOS_W-1:0] r_new_tos;
    t_conn_state      r_conn_state;
    logic             r_table_full;
    logic             r_established;

    logic              tbl_full;
    logic [DSCP_W-1:0] dscp;
    t_conn_state       n_conn_state;
    logic              fwd;
    logic [TOS_W-1:0]  ntos;

    assign tbl_full = (r_next_free == CW'(FLOW_ENTRIES));
    assign dscp     = r_tos[TOS_W-1:ECN_W];

    assign o_sts.tcp   = r_tcp;
    assign o_sts.empty = (r_next_free == '0);
    assign o_sts.hit   = (r_key_rd == r_key);
    assign o_sts.last  = ((CW'(r_idx) + CW'(1)) == r_next_free);

    // handshake step from the entry's old state
    always_comb begin
        n_conn_state = r_old;
        fwd          = 1'b1;
        ntos         = r_tos;
        if (r_dir == CMD_TX) begin
            priority if (r_syn && !r_ack) begin
                n_conn_state = ST_SYN_SENT;
            end else if (r_syn && r_ack && n_conn_state == ST_SYN_RCVD) begin
                n_conn_state = ST_SYNACK_SENT;
            end else begin
            end
            ntos = {r_data_class, r_tos[ECN_W-1:0]};
            if (r_ack && n_conn_state == ST_SYNACK_RCVD) begin
                n_conn_state = ST_ESTABLISHED;
            end
        end else if (dscp == r_credit_class) begin
            fwd = 1'b0;
        end else begin
            if (dscp == r_data_class) begin
                priority if (r_syn && !r_ack) begin
                    n_conn_state = ST_SYN_RCVD;
                end else if (r_syn && r_ack && n_conn_state == ST_SYN_SENT) begin
                    n_conn_state = ST_SYNACK_RCVD;
                end else begin
                end
            end
            if (r_ack && n_conn_state == ST_SYNACK_SENT) begin
                n_conn_state = ST_ESTABLISHED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free    <= '0;
            r_data_class   <= DATA_CLASS_RST;
            r_credit_class <= CREDIT_CLASS_RST;
            r_valid        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DATA_CLASS:   r_data_class   <= i_cfg_data;
                    CFG_CREDIT_CLASS: r_credit_class <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.miss && !tbl_full) begin
                r_next_free <= r_next_free + CW'(1);
            end
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            // receive words are keyed on the swapped tuple
            if (i_cmd_dir == CMD_TX) begin
                r_key <= {i_src_ip, i_dst_ip, i_src_port, i_dst_port};
            end else begin
                r_key <= {i_dst_ip, i_src_ip, i_dst_port, i_src_port};
            end
            r_dir  <= i_cmd_dir;
            r_tcp  <= i_is_ipv4_tcp;
            r_tos  <= i_tos;
            r_syn  <= i_syn;
            r_ack  <= i_ack;
            r_idx  <= '0;
            r_have <= 1'b0;
            r_old  <= ST_CLOSED;
        end
        if (i_cmd.rd_en) begin
            r_key_rd <= r_key_mem[r_idx];
            r_st_rd  <= r_st_mem[r_idx];
        end
        if (i_cmd.inc_idx) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.hit) begin
            r_have <= 1'b1;
            r_old  <= r_st_rd;
        end
        if (i_cmd.miss && !tbl_full) begin
            r_key_mem[r_next_free[IW-1:0]] <= r_key;
            r_idx  <= r_next_free[IW-1:0];
            r_have <= 1'b1;
            r_old  <= ST_CLOSED;
        end
        if (i_cmd.finish) begin
            if (r_tcp && r_have) begin
                r_st_mem[r_idx] <= n_conn_state;
            end
            if (r_tcp) begin
                r_forward     <= fwd;
                r_new_tos     <= ntos;
                r_conn_state  <= r_have ? n_conn_state : ST_CLOSED;
                r_table_full  <= !r_have;
                r_established <= r_have && (n_conn_state == ST_ESTABLISHED)
                                 && (r_old != ST_ESTABLISHED);
            end else begin
                r_forward     <= 1'b1;
                r_new_tos     <= r_tos;
                r_conn_state  <= ST_CLOSED;
                r_table_full  <= 1'b0;
                r_established <= 1'b0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_forward     = r_forward;
    assign o_new_tos     = r_new_tos;
    assign o_conn_state  = r_conn_state;
    assign o_table_full  = r_table_full;
    assign o_established = r_established;

endmodule

/* hdl/flow_handshake_tracker_top.sv */
// Steps: a non-IPv4/TCP word passes check and finish only; a hit at entry j reads and
//   compares entries 0 to j; a miss compares all stored flows and allocates. The result
//   strobe follows the finish state in the next cycle. Throughput: one word per busy
//   period; the scan uses one read port. A new start is taken while a result shows.
// Reset (synchronous, active low) empties the flow table via its fill count and restores
//   the class registers; results have no backpressure.
// ----------------------------------------------------------------------------
// flow_handshake_tracker_top
// Tracks the TCP handshake of each flow from transmit and receive headers,
// rewrites DSCP on transmit and drops credit words on receive.
// ----------------------------------------------------------------------------
module flow_handshake_tracker_top #(
    parameter int FLOW_ENTRIES = fht_pkg::FLOW_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cmd,
    input  logic                          i_is_ipv4_tcp,
    input  logic [fht_pkg::IP_W-1:0]      i_src_ip,
    input  logic [fht_pkg::IP_W-1:0]      i_dst_ip,
    input  logic [fht_pkg::PORT_W-1:0]    i_src_port,
    input  logic [fht_pkg::PORT_W-1:0]    i_dst_port,
    input  logic [fht_pkg::TOS_W-1:0]     i_tos,
    input  logic                          i_syn,
    input  logic                          i_ack,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fht_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fht_pkg::DSCP_W-1:0]    i_cfg_data,
    output logic                          o_valid,
    output logic                          o_forward,
    output logic [fht_pkg::TOS_W-1:0]     o_new_tos,
    output logic [2:0]                    o_conn_state,
    output logic                          o_table_full,
    output logic                          o_established
);
    import fht_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    fht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    fht_dp #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd_dir     (i_cmd),
        .i_is_ipv4_tcp (i_is_ipv4_tcp),
        .i_src_ip      (i_src_ip),
        .i_dst_ip      (i_dst_ip),
        .i_src_port    (i_src_port),
        .i_dst_port    (i_dst_port),
        .i_tos         (i_tos),
        .i_syn         (i_syn),
        .i_ack         (i_ack),
        .o_valid       (o_valid),
        .o_forward     (o_forward),
        .o_new_tos     (o_new_tos),
        .o_conn_state  (o_conn_state),
        .o_table_full  (o_table_full),
        .o_established (o_established)
    );

    // result appears only once the sequencer is back at rest
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (o_conn_state == ST_CLOSED && !o_established))
        else $error("full table result carries a state");

    a_est_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_established) |-> (o_conn_state == ST_ESTABLISHED))
        else $error("established flag without established state");

endmodule
